FILE: rtl/plc_pkg.sv
// Shared constants, codes and types of the positional list engine.
package plc_pkg;

    localparam int DEPTH       = 64;
    localparam int WORD_BITS   = 64;

    localparam int KIND_BITS   = 2;
    localparam int POS_BITS    = 7;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 7;
    localparam int CAP_BITS    = 8;
    localparam int MIN_BITS    = 7;

    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CMP_W       = (CNT_W > POS_BITS) ? CNT_W : POS_BITS;

    localparam int CAP_MAX       = 255;
    localparam int RESET_MIN_CAP = 10;

    // read tree: cells are OR-reduced in groups, then the groups are reduced
    localparam int GRP  = 8;
    localparam int NGRP = (DEPTH + GRP - 1) / GRP;

    localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_OOB  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INS,
        OP_DEL
    } t_cell_op;

    typedef struct packed {
        t_cell_op               op;
        logic                   rd;
        logic [CNT_W-1:0]       idx;
        logic [WORD_BITS-1:0]   value;
    } t_cell_ctl;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [COUNT_BITS-1:0]  count;
        logic [CAP_BITS-1:0]    capacity;
    } t_result;

endpackage

FILE: rtl/plc_cell.sv
// One storage cell of the list row: holds a word and shifts with its neighbors.
module plc_cell (
    input  logic                          i_clk,
    input  logic [plc_pkg::CNT_W-1:0]     i_index,
    input  plc_pkg::t_cell_ctl            i_ctl,
    input  logic [plc_pkg::WORD_BITS-1:0] i_left,
    input  logic [plc_pkg::WORD_BITS-1:0] i_right,
    output logic [plc_pkg::WORD_BITS-1:0] o_word,
    output logic [plc_pkg::WORD_BITS-1:0] o_rd
);
    import plc_pkg::*;

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    always_comb begin
        n_word = r_word;
        unique case (i_ctl.op)
            OP_INS: begin
                if (i_index > i_ctl.idx) begin
                    n_word = i_left;
                end else if (i_index == i_ctl.idx) begin
                    n_word = i_ctl.value;
                end
            end
            OP_DEL: begin
                if (i_index >= i_ctl.idx) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_rd   = (i_ctl.rd && (i_index == i_ctl.idx)) ? r_word : '0;

endmodule

FILE: rtl/plc_ctl.sv
// Operation decode, bounds checks, entry count and logical capacity.
module plc_ctl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [plc_pkg::KIND_BITS-1:0]   i_kind,
    input  logic [plc_pkg::POS_BITS-1:0]    i_pos,
    input  logic                            i_tail,
    input  logic [plc_pkg::WORD_BITS-1:0]   i_value,
    input  logic                            i_cfg_we,
    input  logic [plc_pkg::MIN_BITS-1:0]    i_cfg_wdata,
    output plc_pkg::t_cell_ctl              o_cell,
    output plc_pkg::t_result                o_res
);
    import plc_pkg::*;

    localparam int RZ_W = ((CNT_W > CAP_BITS) ? CNT_W : CAP_BITS) + 2;

    logic [CNT_W-1:0]    r_count;
    logic [CAP_BITS-1:0] r_cap;
    logic [MIN_BITS-1:0] r_min;

    logic [CNT_W-1:0]       n_count;
    logic [CAP_BITS-1:0]    n_cap;
    logic [STATUS_BITS-1:0] status;
    t_cell_op               op;
    logic                   rd;
    logic [CMP_W-1:0]       pos_c;
    logic [CMP_W-1:0]       cnt_c;
    logic [CMP_W-1:0]       idx_c;
    logic [CNT_W-1:0]       nc;
    logic [CAP_BITS:0]      dbl;
    logic [CAP_BITS-1:0]    cap1;
    logic [CAP_BITS-1:0]    half;
    logic [CAP_BITS-1:0]    min_c;
    logic [RZ_W-1:0]        thr;
    logic [MIN_BITS-1:0]    cfg_min;

    assign pos_c   = CMP_W'(i_pos);
    assign cnt_c   = CMP_W'(r_count);
    assign min_c   = CAP_BITS'(r_min);
    assign cfg_min = (i_cfg_wdata == '0) ? MIN_BITS'(1) : i_cfg_wdata;

    // decode and bounds
    always_comb begin
        status = ST_DONE;
        op     = OP_HOLD;
        rd     = 1'b0;
        idx_c  = pos_c;
        unique case (i_kind) inside
            KIND_INSERT: begin
                idx_c = i_tail ? (cnt_c - pos_c) : pos_c;
                if (pos_c > cnt_c) begin
                    status = ST_OOB;
                end else if (cnt_c >= CMP_W'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    op = OP_INS;
                end
            end
            KIND_DELETE, KIND_READ: begin
                idx_c = i_tail ? (cnt_c - CMP_W'(1) - pos_c) : pos_c;
                if (pos_c >= cnt_c) begin
                    status = ST_OOB;
                end else if (i_kind == KIND_DELETE) begin
                    op = OP_DEL;
                end else begin
                    rd = 1'b1;
                end
            end
            default: begin
                status = ST_OOB;
            end
        endcase
    end

    // count update and capacity hysteresis
    always_comb begin
        nc    = (op == OP_INS) ? (r_count + CNT_W'(1)) : (r_count - CNT_W'(1));
        dbl   = {r_cap, 1'b0};
        cap1  = r_cap;
        if (RZ_W'(nc) >= RZ_W'(r_cap)) begin
            cap1 = (dbl > (CAP_BITS + 1)'(CAP_MAX)) ? CAP_BITS'(CAP_MAX) : dbl[CAP_BITS-1:0];
        end
        // count < cap/3 is the same as 3*count + 3 <= cap
        thr   = (RZ_W'(nc) << 1) + RZ_W'(nc) + RZ_W'(3);
        half  = cap1 >> 1;
        n_cap = cap1;
        if ((thr <= RZ_W'(cap1)) && (cap1 > min_c)) begin
            n_cap = (half < min_c) ? min_c : half;
        end
        if (op == OP_HOLD) begin
            n_count = r_count;
            n_cap   = r_cap;
        end else begin
            n_count = nc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_min   <= MIN_BITS'(RESET_MIN_CAP);
            r_cap   <= CAP_BITS'(RESET_MIN_CAP);
        end else if (i_cfg_we) begin
            r_min <= cfg_min;
            r_cap <= CAP_BITS'(cfg_min);
        end else if (i_accept) begin
            r_count <= n_count;
            r_cap   <= n_cap;
        end
    end

    always_comb begin
        o_cell.op    = i_accept ? op : OP_HOLD;
        o_cell.rd    = rd;
        o_cell.idx   = CNT_W'(idx_c);
        o_cell.value = i_value;
    end

    assign o_res.status   = status;
    assign o_res.count    = COUNT_BITS'(n_count);
    assign o_res.capacity = n_cap;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count beyond store depth");

    a_cap_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap >= CAP_BITS'(r_min))
        else $error("logical capacity below minimum");

    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_cfg_we && (status != ST_DONE)) |=> (r_count == $past(r_count)))
        else $error("failed operation changed the count");

    a_ins_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_cfg_we && (op == OP_INS))
            |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not advance the count");

endmodule

FILE: rtl/positional_list_engine.sv
// Top level of the positional list engine: cell row, read tree and output register.
//
//  channel   dir  handshake                          payload
//  s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata: position, value; tuser: kind, from_tail
//  m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata: read_value, count, capacity; tuser: status
//  cfg       in   i_cfg_we (no wait)                 i_cfg_wdata: min_capacity
//
// An item is decoded and applied to the cell row in the cycle it is accepted; every cell shifts
// at once, whatever the position. A read goes through a two-level OR tree split by the stage-1
// register; every result moves from the stage-1 register into the output register. Sustained
// rate is one item per cycle while the output is not stalled. Reset (synchronous, active low)
// clears count and valid flags and loads capacity and min_capacity with their reset minimum;
// stored words stay undefined until written. A stalled output holds its result and the stage
// behind it; input ready drops only when both are full.
module positional_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // position[6:0], value[70:7], zero pad[71]
    input  logic [2:0]  i_s_axis_tuser,   // kind[1:0], from_tail[2]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // read_value[63:0], count[70:64], capacity[78:71], pad
    output logic [1:0]  o_m_axis_tuser,   // status[1:0]
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata       // min_capacity
);
    import plc_pkg::*;

    logic      accept;
    logic      s1_adv;
    t_cell_ctl cell_ctl;
    t_result   res;

    logic [WORD_BITS-1:0] w_word [DEPTH];
    logic [WORD_BITS-1:0] w_rd   [DEPTH];
    logic [WORD_BITS-1:0] grp_or [NGRP];
    logic [WORD_BITS-1:0] tree_or;

    // stage 1: group partial reads plus the decoded result fields
    logic                 r_s1_valid;
    logic [WORD_BITS-1:0] r_s1_grp [NGRP];
    t_result              r_s1_res;

    // output register
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_rd;
    t_result              r_out_res;

    // advance stage 1 whenever the output register is free or being emptied
    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    plc_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_kind      (i_s_axis_tuser[1:0]),
        .i_pos       (i_s_axis_tdata[6:0]),
        .i_tail      (i_s_axis_tuser[2]),
        .i_value     (i_s_axis_tdata[70:7]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cell      (cell_ctl),
        .o_res       (res)
    );

    // cell row: past the index cells take the left word on insert; from it on, the right on delete
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_BITS-1:0] left_w;
        logic [WORD_BITS-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = w_word[g+1];
        end
        plc_cell u_cell (
            .i_clk   (i_clk),
            .i_index (CNT_W'(g)),
            .i_ctl   (cell_ctl),
            .i_left  (left_w),
            .i_right (right_w),
            .o_word  (w_word[g]),
            .o_rd    (w_rd[g])
        );
    end

    // first tree level: OR each group of cell read ports (only the addressed cell is nonzero)
    always_comb begin
        for (int k = 0; k < NGRP; k++) begin
            grp_or[k] = '0;
            for (int j = 0; j < GRP; j++) begin
                if (k * GRP + j < DEPTH) begin
                    grp_or[k] = grp_or[k] | w_rd[k * GRP + j];
                end
            end
        end
    end

    // second tree level over the registered groups
    always_comb begin
        tree_or = '0;
        for (int k = 0; k < NGRP; k++) begin
            tree_or = tree_or | r_s1_grp[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // capture the read snapshot at acceptance, before the row shifts again
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_grp <= grp_or;
            r_s1_res <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_rd  <= tree_or;
            r_out_res <= r_s1_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_res.capacity, r_out_res.count, r_out_rd};
    assign o_m_axis_tuser  = r_out_res.status;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> (r_out_valid && $stable(r_out_rd)))
        else $error("stalled result changed");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |-> !o_s_axis_tready)
        else $error("input taken while stage 1 is blocked");

    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_res.status != ST_DONE)) |-> (r_out_rd == '0))
        else $error("failed operation returned a nonzero word");

endmodule

FILE: sim/tb_top.sv
// Testbench for the positional list engine: random and directed operations vs a scoreboard.
`timescale 1ns / 100ps

module tb_top;
    import plc_pkg::*;

    // Generous cycle bound: about 2000 items, plus stalls and pauses.
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 285;

    // One expected result of a list operation.
    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [WORD_BITS-1:0]   read_value;
        logic [COUNT_BITS-1:0]  count;
        logic [CAP_BITS-1:0]    capacity;
    } t_list_result;

    // Shadow copy of the list, its count and its hysteresis capacity, plus the queue of
    // results still owed by the block.
    class list_scoreboard;
        logic [WORD_BITS-1:0] words[DEPTH];
        int unsigned          n_entries;
        int unsigned          cap;
        int unsigned          min_cap;
        t_list_result         owed_q[$];
        int                   mismatches;
        int                   n_done, n_oob, n_full;
        int unsigned          peak_count, peak_cap;

        function new();
            n_entries = 0;
            min_cap   = RESET_MIN_CAP;
            cap       = min_cap;
            peak_cap  = cap;
        endfunction

        // A register write reloads the capacity as well; zero counts as one.
        function void set_min(input logic [MIN_BITS-1:0] v);
            min_cap = (v == '0) ? 32'd1 : 32'(v);
            cap     = min_cap;
        endfunction

        // Grow when the count reaches the capacity, shrink when it falls under a third.
        function void resize();
            if (n_entries >= cap)
                cap = (cap * 2 > CAP_MAX) ? CAP_MAX : cap * 2;
            if (n_entries < cap / 3 && cap > min_cap)
                cap = (cap / 2 < min_cap) ? min_cap : cap / 2;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // Apply one accepted item to the shadow list and queue its result.
        function void note_item(input logic [KIND_BITS-1:0] kind, input logic [POS_BITS-1:0] pos,
                                input logic tail, input logic [WORD_BITS-1:0] val);
            t_list_result want;
            int unsigned  p, idx, i;
            p               = 32'(pos);
            want.status     = ST_DONE;
            want.read_value = '0;
            if (kind == KIND_INSERT) begin
                if (p > n_entries) begin
                    want.status = ST_OOB;
                end else if (n_entries >= DEPTH) begin
                    want.status = ST_FULL;
                end else begin
                    idx = tail ? n_entries - p : p;
                    for (i = n_entries; i > idx; i--)
                        words[i] = words[i-1];
                    words[idx] = val;
                    n_entries++;
                    resize();
                end
            end else if (kind == KIND_DELETE || kind == KIND_READ) begin
                if (p >= n_entries) begin
                    want.status = ST_OOB;
                end else begin
                    idx = tail ? n_entries - 1 - p : p;
                    if (kind == KIND_READ) begin
                        want.read_value = words[idx];
                    end else begin
                        for (i = idx; i + 1 < n_entries; i++)
                            words[i] = words[i+1];
                        n_entries--;
                        resize();
                    end
                end
            end else begin
                want.status = ST_OOB;
            end
            want.count    = n_entries[COUNT_BITS-1:0];
            want.capacity = cap[CAP_BITS-1:0];
            case (want.status)
                ST_DONE: n_done++;
                ST_OOB:  n_oob++;
                default: n_full++;
            endcase
            if (n_entries > peak_count) peak_count = n_entries;
            if (cap > peak_cap) peak_cap = cap;
            owed_q.push_back(want);
        endfunction

        function void report(input string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch: %s", $realtime, what);
        endfunction

        // Compare one result from the block with the oldest owed result.
        function void check_result(input logic [STATUS_BITS-1:0] status,
                                   input logic [WORD_BITS-1:0] rd,
                                   input logic [COUNT_BITS-1:0] cnt,
                                   input logic [CAP_BITS-1:0] capv);
            t_list_result want;
            if (owed_q.size() == 0) begin
                report($sformatf("result with nothing owed: status %0d read %h count %0d cap %0d",
                                 status, rd, cnt, capv));
                return;
            end
            want = owed_q.pop_front();
            if (status !== want.status || rd !== want.read_value ||
                cnt !== want.count || capv !== want.capacity)
                report($sformatf({"expected status %0d read %h count %0d cap %0d, ",
                                  "got status %0d read %h count %0d cap %0d"},
                                 want.status, want.read_value, want.count, want.capacity,
                                 status, rd, cnt, capv));
        endfunction
    endclass

    logic                 i_clk;
    logic                 rst_n   = 1'b0;
    logic                 s_valid = 1'b0;
    logic [71:0]          s_data  = '0;
    logic [2:0]           s_user  = '0;
    logic                 m_ready = 1'b0;
    logic                 cfg_we  = 1'b0;
    logic [MIN_BITS-1:0]  cfg_wdata = '0;
    logic                 s_ready;
    logic                 m_valid;
    logic [79:0]          m_data;
    logic [1:0]           m_user;

    list_scoreboard sb = new();
    bit             steady = 1'b0;   // set while neither side may idle
    int             cycles = 0;
    int             n_items = 0;

    positional_list_engine DUT (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // position[6:0], value[70:7], zero pad[71]
        .i_s_axis_tuser  (s_user),    // kind[1:0], from_tail[2]
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),    // read_value[63:0], count[70:64], capacity[78:71]
        .o_m_axis_tuser  (m_user),    // status[1:0]
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)  // min_capacity
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Watchdog: end the run with an error once the cycle count passes the bound.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: stall at random about 31 percent of the time, except inside the steady stretch.
    always @(negedge i_clk)
        m_ready <= steady || ($urandom_range(0, 99) >= 31);

    // Sample each accepted result at the rising edge and check it.
    always @(posedge i_clk)
        if (rst_n && m_valid && m_ready)
            sb.check_result(m_user, m_data[63:0], m_data[70:64], m_data[78:71]);

    // Offer one item, with random idle cycles ahead of it, and hold it until accepted.
    // Leave tvalid high afterwards; the idle cycles of the next call or a drain lower it.
    task automatic send_op(input logic [KIND_BITS-1:0] kind, input logic [POS_BITS-1:0] pos,
                           input logic tail, input logic [WORD_BITS-1:0] val);
        while (!steady && $urandom_range(0, 99) < 31) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= {1'b0, val, pos};
        s_user  <= {tail, kind};
        do @(posedge i_clk); while (!s_ready);
        sb.note_item(kind, pos, tail, val);
        n_items++;
    endtask

    // Drop tvalid and hold until every owed result has come back.
    task automatic drain();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // Write min_capacity with the block idle; allow the two-stage read path to settle first.
    task automatic write_min(input logic [MIN_BITS-1:0] v);
        drain();
        repeat (4) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        sb.set_min(v);
    endtask

    // Random word, with the all-zero and all-one words mixed in.
    function automatic logic [WORD_BITS-1:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed operations with positions in range; a little noise with any
    // kind and any position. The insert share steers the list toward full or empty.
    task automatic run_phase(input int n_ops, input int ins_share, input bit pause_mid);
        logic [KIND_BITS-1:0] kind;
        logic [POS_BITS-1:0]  pos;
        int unsigned          n, r;
        for (int k = 0; k < n_ops; k++) begin
            if (pause_mid && k == n_ops / 2)
                drain();
            n = sb.n_entries;
            r = $urandom_range(0, 99);
            if (r < 8) begin
                kind = KIND_BITS'($urandom_range(0, 3));
                pos  = POS_BITS'($urandom_range(0, 127));
            end else begin
                if ($urandom_range(0, 99) < ins_share) begin
                    kind = KIND_INSERT;
                    pos  = POS_BITS'((r < 18) ? ((r < 13) ? 0 : n) : $urandom_range(0, n));
                end else begin
                    kind = ($urandom_range(0, 1) == 0) ? KIND_DELETE : KIND_READ;
                    if (n == 0)
                        pos = '0;
                    else
                        pos = POS_BITS'((r < 18) ? ((r < 13) ? 0 : n - 1)
                                                 : $urandom_range(0, n - 1));
                end
            end
            send_op(kind, pos, 1'($urandom_range(0, 1)), pick_word());
        end
    endtask

    localparam int PHASE_INS[PHASES] = '{70, 85, 15, 70, 30, 55, 40};

    initial begin
        logic [MIN_BITS-1:0] min_vals[PHASES];
        min_vals = '{7'd10, 7'd64, 7'd1, 7'd127, 7'd0, 7'd10, 7'd32};
        min_vals[5] = MIN_BITS'($urandom_range(2, 63));

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Directed: empty-list errors, head and tail inserts at both ends, reads from
        // both ends, the unused kind, out-of-range positions, deletes back to empty.
        send_op(KIND_DELETE, 7'd0, 1'b0, '0);
        send_op(KIND_READ,   7'd0, 1'b1, '0);
        send_op(KIND_INSERT, 7'd1, 1'b0, '1);
        send_op(KIND_INSERT, 7'd0, 1'b0, '1);
        send_op(KIND_INSERT, 7'd0, 1'b1, '0);
        send_op(KIND_INSERT, 7'd2, 1'b0, 64'h8000_0000_0000_0001);
        send_op(KIND_INSERT, 7'd3, 1'b1, 64'hA5A5_5A5A_C3C3_3C3C);
        send_op(KIND_INSERT, 7'd2, 1'b1, 64'h0123_4567_89AB_CDEF);
        send_op(KIND_READ,   7'd0, 1'b0, '1);
        send_op(KIND_READ,   7'd0, 1'b1, '0);
        send_op(KIND_READ,   7'd4, 1'b1, '0);
        send_op(KIND_READ,   7'd4, 1'b0, '0);
        send_op(KIND_READ,   7'd5, 1'b0, '0);
        send_op(KIND_UNUSED, 7'd0, 1'b0, '1);
        send_op(KIND_READ,   7'd127, 1'b1, '0);
        send_op(KIND_INSERT, 7'd127, 1'b1, '1);
        send_op(KIND_DELETE, 7'd64, 1'b0, '0);
        send_op(KIND_DELETE, 7'd0, 1'b1, '0);
        send_op(KIND_DELETE, 7'd0, 1'b0, '0);
        send_op(KIND_DELETE, 7'd1, 1'b1, '0);
        send_op(KIND_DELETE, 7'd1, 1'b0, '0);
        send_op(KIND_DELETE, 7'd0, 1'b1, '0);
        send_op(KIND_DELETE, 7'd0, 1'b0, '0);

        // Random phases, each under its own min_capacity; phase 3 runs without idling
        // and phase 5 pauses halfway until every result is back.
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0)
                write_min(min_vals[ph]);
            steady = (ph == 3);
            run_phase(PHASE_ITEMS, PHASE_INS[ph], ph == 5);
        end
        steady = 1'b0;

        drain();
        repeat (8) @(posedge i_clk);

        $display("covered %0d list operations: %0d done, %0d out of bounds, %0d store full",
                 n_items, sb.n_done, sb.n_oob, sb.n_full);
        $display("peak entry count %0d, peak capacity %0d, %0d mismatches",
                 sb.peak_count, sb.peak_cap, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
